FILE: rtl/biir4_pkg.sv
// Shared types, constants and coefficient helpers for the fourth-order IIR.
// Used by biir4_cell and butterworth_iir4_fixed_point; depends on nothing.
`default_nettype none

package biir4_pkg;

  localparam int X_W            = 16;
  localparam int Y_W            = 32;
  localparam int COEF_BASE_BITS = 24;
  localparam int NUM_TAPS       = 5;
  localparam int DEN_TAPS       = 4;

  typedef logic signed [X_W-1:0] sample_t;
  typedef logic signed [Y_W-1:0] word_t;

  // Coefficient magnitudes at 2^24, truncated. Shifting them down gives the
  // same truncation toward zero as scaling the real values directly.
  localparam longint NUM_MAG24 [NUM_TAPS] = '{223, 892, 1338, 892, 223};
  localparam longint DEN_MAG24 [DEN_TAPS] = '{61601392, 85026903, 52277250, 12078091};
  localparam bit     DEN_NEG   [DEN_TAPS] = '{1'b1, 1'b0, 1'b1, 1'b0};

  function automatic longint num_coef(input int k, input int frac);
    return NUM_MAG24[k] >>> (COEF_BASE_BITS - frac);
  endfunction

  function automatic longint den_coef(input int k, input int frac);
    longint m;
    m = DEN_MAG24[k] >>> (COEF_BASE_BITS - frac);
    return DEN_NEG[k] ? -m : m;
  endfunction

  // Numerator term: a small constant times the sample, modulo 2^32.
  function automatic word_t num_prod(input sample_t x, input int k, input int frac);
    longint p;
    p = longint'(x) * num_coef(k, frac);
    return word_t'(p[Y_W-1:0]);
  endfunction

endpackage

`default_nettype wire

FILE: rtl/butterworth_iir4_fixed_point.sv
// Fourth-order direct-form-I low-pass IIR filter, top level.
// Depends on biir4_pkg and biir4_cell.
//
// Usage: each word on the input channel (sample_in_i, 16-bit signed) yields
// exactly one word on the output channel (filtered_out_o, 32-bit signed,
// scaled by 2^FRAC_BITS and wrapping modulo 2^32). Both channels use
// valid/ready. A word is accepted when in_valid_i and in_ready_o are high.
// The result is written to the output register as the word is accepted.
// Throughput is one word per cycle unless the receiver stalls; the limit is
// the feedback loop through the first cell, one multiply and the output sum.
// A row of four cells holds the input and output history; the outer cells
// precompute their feedback products as the history moves along.
// While the receiver stalls with a word held, in_ready_o follows out_ready_i,
// so the held word never changes and the next word enters as it is taken.
// Reset clears the history, the pending output and all valid state.
`default_nettype none

module butterworth_iir4_fixed_point #(
  parameter int FRAC_BITS = 19
) (
  input  wire                clk_i,
  input  wire                rst_ni,
  input  wire                in_valid_i,
  output logic               in_ready_o,
  input  wire  signed [15:0] sample_in_i,
  output logic               out_valid_o,
  input  wire                out_ready_i,
  output logic signed [31:0] filtered_out_o
);

  localparam int NT = biir4_pkg::DEN_TAPS;

  biir4_pkg::sample_t x_chain [NT+1];
  biir4_pkg::word_t   y_chain [NT+1];
  biir4_pkg::word_t   num_terms [NT];
  biir4_pkg::word_t   den_terms [NT];
  biir4_pkg::word_t   num_sum;
  biir4_pkg::word_t   den_sum;
  biir4_pkg::word_t   y_new;

  logic             in_fire;
  logic             out_valid_q;
  logic             out_valid_d;
  biir4_pkg::word_t out_data_q;

  assign in_ready_o = !out_valid_q || out_ready_i;
  assign in_fire    = in_valid_i && in_ready_o;

  assign x_chain[0] = sample_in_i;
  assign y_chain[0] = y_new;

  generate
    for (genvar k = 1; k <= NT; k++) begin : g_cell
      biir4_cell #(
        .FRAC_BITS (FRAC_BITS),
        .TAP       (k),
        .PRE_MUL   (k != 1)
      ) u_cell (
        .clk_i      (clk_i),
        .rst_ni     (rst_ni),
        .shift_i    (in_fire),
        .x_i        (x_chain[k-1]),
        .y_i        (y_chain[k-1]),
        .x_o        (x_chain[k]),
        .y_o        (y_chain[k]),
        .num_term_o (num_terms[k-1]),
        .den_term_o (den_terms[k-1])
      );
    end
  endgenerate

  always_comb begin
    num_sum = biir4_pkg::num_prod(sample_in_i, 0, FRAC_BITS);
    den_sum = '0;
    for (int i = 0; i < NT; i++) begin
      num_sum = num_sum + num_terms[i];
      den_sum = den_sum + den_terms[i];
    end
    y_new = num_sum - den_sum;
  end

  always_comb begin
    out_valid_d = out_valid_q;
    if (in_fire) begin
      out_valid_d = 1'b1;
    end else if (out_ready_i) begin
      out_valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else begin
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_data_q <= '0;
    end else if (in_fire) begin
      out_data_q <= y_new;
    end
  end

  assign out_valid_o    = out_valid_q;
  assign filtered_out_o = out_data_q;

  a_fire_gives_word: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_fire |=> out_valid_o)
    else $error("accepted sample did not produce an output word");

  a_word_matches_sum: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_fire |=> filtered_out_o == $past(y_new))
    else $error("output word differs from the computed sum");

  a_history_tracks_output: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_fire |=> y_chain[1] == filtered_out_o)
    else $error("first cell does not hold the delivered word");

  a_idle_holds_history: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !in_fire |=> $stable(y_chain[1]) && $stable(x_chain[1]))
    else $error("filter history moved without an accepted sample");

endmodule

`default_nettype wire

FILE: rtl/biir4_cell.sv
// One delay cell of the filter: holds x[n-k] and y[n-k] and forms their terms.
// Depends on biir4_pkg.
`default_nettype none

module biir4_cell #(
  parameter int FRAC_BITS = 19,
  parameter int TAP       = 1,
  parameter bit PRE_MUL   = 1'b1
) (
  input  wire                   clk_i,
  input  wire                   rst_ni,
  input  wire                   shift_i,
  input  biir4_pkg::sample_t    x_i,
  input  biir4_pkg::word_t      y_i,
  output biir4_pkg::sample_t    x_o,
  output biir4_pkg::word_t      y_o,
  output biir4_pkg::word_t      num_term_o,
  output biir4_pkg::word_t      den_term_o
);

  localparam int AW = FRAC_BITS + 4;
  localparam int PW = biir4_pkg::Y_W + AW;
  localparam logic signed [AW-1:0] ACOEF =
    AW'(biir4_pkg::den_coef(TAP - 1, FRAC_BITS));

  biir4_pkg::sample_t x_q;
  biir4_pkg::word_t   y_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      x_q <= '0;
      y_q <= '0;
    end else if (shift_i) begin
      x_q <= x_i;
      y_q <= y_i;
    end
  end

  assign x_o        = x_q;
  assign y_o        = y_q;
  assign num_term_o = biir4_pkg::num_prod(x_q, TAP, FRAC_BITS);

  generate
    if (PRE_MUL) begin : g_pre
      // The product for the next word is formed from the neighbor's stored
      // output as it moves in, so only a register feeds the output sum.
      logic signed [PW-1:0] prod;
      biir4_pkg::word_t     den_q;
      biir4_pkg::word_t     den_d;

      assign prod  = y_i * ACOEF;
      assign den_d = prod[FRAC_BITS+biir4_pkg::Y_W-1:FRAC_BITS];

      always_ff @(posedge clk_i or negedge rst_ni) begin
        if (!rst_ni) begin
          den_q <= '0;
        end else if (shift_i) begin
          den_q <= den_d;
        end
      end

      assign den_term_o = den_q;
    end else begin : g_direct
      // The first cell sits inside the one-word feedback loop.
      logic signed [PW-1:0] prod;

      assign prod       = y_q * ACOEF;
      assign den_term_o = prod[FRAC_BITS+biir4_pkg::Y_W-1:FRAC_BITS];
    end
  endgenerate

endmodule

`default_nettype wire

FILE: verif/tb_top.sv
`timescale 1ns / 1ps
// Self-checking bench for the fourth-order fixed-point IIR low-pass filter.
// Depends on biir4_pkg for the sample and word types and on the filter top level.

module tb_top;

  localparam int FRAC_BITS     = 19;
  localparam int STALL_LIMIT   = 3000;
  localparam int HOLD_CYCLES   = 300;
  localparam int TAIL_CYCLES   = 8;

  // Coefficients for 19 fractional bits, truncated toward zero.
  localparam longint FF_COEF [5] = '{6, 27, 41, 27, 6};
  localparam longint FB_COEF [4] = '{-1925043, 2657090, -1633664, 377440};

  typedef enum logic [1:0] {RX_ALWAYS, RX_RANDOM, RX_PATTERN} rx_mode_e;

  logic               clk_i       = 1'b0;
  logic               rst_ni      = 1'b0;
  logic               in_valid_i  = 1'b0;
  biir4_pkg::sample_t sample_in_i = '0;
  logic               out_ready_i = 1'b0;
  logic               in_ready_o;
  logic               out_valid_o;
  biir4_pkg::word_t   filtered_out_o;

  butterworth_iir4_fixed_point #(
    .FRAC_BITS(FRAC_BITS)
  ) uut (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .in_valid_i    (in_valid_i),
    .in_ready_o    (in_ready_o),
    .sample_in_i   (sample_in_i),
    .out_valid_o   (out_valid_o),
    .out_ready_i   (out_ready_i),
    .filtered_out_o(filtered_out_o)
  );

  always begin
    #5 clk_i = 1'b1;
    #5 clk_i = 1'b0;
  end

  // Filter history as the bench sees it, newest entry at index 0.
  biir4_pkg::sample_t x_hist [4];
  biir4_pkg::word_t   y_hist [4];
  biir4_pkg::word_t   pending_outputs [$];
  int                 error_count  = 0;
  int                 quiet_cycles = 0;
  biir4_pkg::sample_t last_sample  = '0;

  rx_mode_e rx_mode      = RX_ALWAYS;
  logic [7:0] rx_pattern = 8'hFF;
  logic [2:0] rx_phase   = '0;
  int       hold_request = 0;
  int       hold_left    = 0;

  // Direct-form-I step: feedforward products wrap at 32 bits, each feedback
  // product is floor-shifted and truncated on its own.
  function automatic biir4_pkg::word_t filter_step(input biir4_pkg::sample_t x);
    logic [31:0]      ff_sum;
    logic [31:0]      fb_sum;
    longint           prod;
    biir4_pkg::word_t y;
    ff_sum = '0;
    fb_sum = '0;
    prod   = FF_COEF[0] * longint'(x);
    ff_sum += prod[31:0];
    for (int k = 1; k < 5; k++) begin
      prod = FF_COEF[k] * longint'(x_hist[k-1]);
      ff_sum += prod[31:0];
    end
    for (int k = 0; k < 4; k++) begin
      prod = (FB_COEF[k] * longint'(y_hist[k])) >>> FRAC_BITS;
      fb_sum += prod[31:0];
    end
    y = biir4_pkg::word_t'(ff_sum - fb_sum);
    for (int k = 3; k > 0; k--) begin
      x_hist[k] = x_hist[k-1];
      y_hist[k] = y_hist[k-1];
    end
    x_hist[0] = x;
    y_hist[0] = y;
    return y;
  endfunction

  // Predict on every accepted input word, then check every accepted output word.
  always @(posedge clk_i) begin
    if (rst_ni && in_valid_i && in_ready_o) begin
      pending_outputs.push_back(filter_step(sample_in_i));
    end
    if (rst_ni && out_valid_o && out_ready_i) begin
      if (pending_outputs.size() == 0) begin
        $error("filtered_out: unexpected word, actual %0d", filtered_out_o);
        error_count++;
      end else begin
        biir4_pkg::word_t want;
        want = pending_outputs.pop_front();
        if (filtered_out_o !== want) begin
          $error("filtered_out: expected %0d, actual %0d", want, filtered_out_o);
          error_count++;
        end
      end
    end
  end

  // Output side: a requested hold-off takes priority over the current mode.
  always @(posedge clk_i) begin
    if (hold_request > 0) begin
      hold_left    = hold_request;
      hold_request = 0;
    end
    if (hold_left > 0) begin
      out_ready_i <= 1'b0;
      hold_left--;
    end else begin
      case (rx_mode)
        RX_ALWAYS: out_ready_i <= 1'b1;
        RX_RANDOM: out_ready_i <= ($urandom_range(0, 99) < 65);
        default: begin
          out_ready_i <= rx_pattern[rx_phase];
          rx_phase    <= rx_phase + 3'd1;
        end
      endcase
    end
  end

  // Watchdog on cycles where neither channel moves a word.
  always @(posedge clk_i) begin
    if ((in_valid_i && in_ready_o) || (out_valid_o && out_ready_i)) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles >= STALL_LIMIT) begin
      $display("FAILURE");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  task automatic send_sample(input biir4_pkg::sample_t x);
    in_valid_i  <= 1'b1;
    sample_in_i <= x;
    do @(posedge clk_i); while (!in_ready_o);
  endtask

  task automatic idle_cycles(input int n);
    in_valid_i <= 1'b0;
    repeat (n) @(posedge clk_i);
  endtask

  // Waits on the clock before checking the queue, so the word accepted at the previous edge is already queued.
  task automatic wait_drain();
    in_valid_i <= 1'b0;
    @(posedge clk_i);
    while (pending_outputs.size() != 0) @(posedge clk_i);
  endtask

  function automatic biir4_pkg::sample_t pick_sample();
    int walk;
    case ($urandom_range(0, 9))
      0, 1, 2, 3: last_sample = biir4_pkg::sample_t'($urandom);
      4, 5: begin
        walk        = int'($urandom_range(0, 512)) - 256;
        last_sample = biir4_pkg::sample_t'(walk);
      end
      6: begin
        case ($urandom_range(0, 3))
          0: last_sample = 16'sh7FFF;
          1: last_sample = biir4_pkg::sample_t'(16'h8000);
          2: last_sample = '0;
          default: last_sample = '1;
        endcase
      end
      7: ; // hold the previous value to form steps
      default: begin
        walk = int'(last_sample) + int'($urandom_range(0, 2048)) - 1024;
        if (walk > 32767) walk = 32767;
        if (walk < -32768) walk = -32768;
        last_sample = biir4_pkg::sample_t'(walk);
      end
    endcase
    return last_sample;
  endfunction

  // Full-scale levels and sign flips after a zero input.
  task automatic test_extremes();
    rx_mode = RX_ALWAYS;
    repeat (2) send_sample('0);
    repeat (4) send_sample(16'sh7FFF);
    repeat (4) send_sample(biir4_pkg::sample_t'(16'h8000));
    repeat (2) begin
      send_sample(16'sh7FFF);
      send_sample(biir4_pkg::sample_t'(16'h8000));
    end
    wait_drain();
  endtask

  // Impulse response of the smallest and largest magnitudes.
  task automatic test_impulse();
    send_sample(16'sh0001);
    repeat (3) send_sample('0);
    send_sample('1);
    send_sample(biir4_pkg::sample_t'(16'h8000));
    repeat (2) send_sample('0);
    wait_drain();
  endtask

  task automatic test_random_traffic(input int n_items, input rx_mode_e mode,
                                     input int max_gap);
    int sent;
    int burst;
    sent       = 0;
    rx_mode    = mode;
    rx_pattern = 8'($urandom) | 8'h01;
    while (sent < n_items) begin
      burst = $urandom_range(1, 40);
      for (int i = 0; i < burst && sent < n_items; i++) begin
        send_sample(pick_sample());
        sent++;
      end
      if (max_gap > 0 && $urandom_range(0, 3) != 0) idle_cycles($urandom_range(1, max_gap));
      if ($urandom_range(0, 19) == 0) wait_drain();
    end
    wait_drain();
  endtask

  // The output side holds off while input words keep coming, so the filter
  // fills and must stall its input without losing or reordering words.
  task automatic test_backpressure();
    rx_mode      = RX_RANDOM;
    hold_request = HOLD_CYCLES;
    @(posedge clk_i);
    repeat (30) send_sample(pick_sample());
    wait_drain();
  endtask

  initial begin
    for (int k = 0; k < 4; k++) begin
      x_hist[k] = '0;
      y_hist[k] = '0;
    end
    repeat (6) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    test_extremes();
    test_impulse();
    test_random_traffic(500, RX_RANDOM, 8);
    test_backpressure();
    test_random_traffic(350, RX_PATTERN, 5);
    test_random_traffic(200, RX_ALWAYS, 0);
    test_backpressure();
    test_random_traffic(150, RX_RANDOM, 3);

    in_valid_i <= 1'b0;
    while (pending_outputs.size() != 0) @(posedge clk_i);
    repeat (TAIL_CYCLES) @(posedge clk_i);
    if (pending_outputs.size() != 0) begin
      $error("filtered_out: %0d expected words never arrived", pending_outputs.size());
      error_count++;
    end
    if (error_count == 0) begin
      $display("SUCCESS");
    end else begin
      $display("FAILURE");
    end
    $finish;
  end

endmodule
